// ===== sv/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// ame_pkg
// types and opcode constants of the accumulator machine execute unit
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int WORD_W  = 16;
    localparam int OP_W    = 4;
    // reciprocal width for constant modulo, enough for any depth of 16 or more
    localparam int RECIP_W = 29;
    // quotient of a 16-bit word by a depth of 16 or more
    localparam int QUOT_W  = 12;

    localparam logic [OP_W-1:0] OP_HLT = 4'd0;
    localparam logic [OP_W-1:0] OP_IN  = 4'd1;
    localparam logic [OP_W-1:0] OP_OUT = 4'd2;
    localparam logic [OP_W-1:0] OP_LDA = 4'd3;
    localparam logic [OP_W-1:0] OP_STA = 4'd4;
    localparam logic [OP_W-1:0] OP_ADD = 4'd5;
    localparam logic [OP_W-1:0] OP_SUB = 4'd6;
    localparam logic [OP_W-1:0] OP_INC = 4'd7;
    localparam logic [OP_W-1:0] OP_DEC = 4'd8;
    localparam logic [OP_W-1:0] OP_JMP = 4'd9;
    localparam logic [OP_W-1:0] OP_JZ  = 4'd10;
    localparam logic [OP_W-1:0] OP_JN  = 4'd11;
    localparam logic [OP_W-1:0] OP_LIT = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [WORD_W-1:0] operand;
        logic signed [WORD_W-1:0] in_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]               next_pc;
        logic signed [WORD_W-1:0] acc_value;
        logic                     out_valid;
        logic                     halted;
    } t_out_item;

endpackage

// ===== sv/accumulator_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// accumulator_machine_execute_unit
// executes one instruction of a 16-bit accumulator machine per transfer
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
//  one instruction per cycle sustained while the output is ready; an input
//  transfer reaches the result through three register stages (operand
//  quotient, address and memory read, execute into the result register)
//  the single-cycle rate is held by the execute stage, which reads the
//  accumulator and pc registers directly and bypasses a same-cycle store
//  reset clears all valid flags and the memory valid bits, so the unit
//  takes input right after reset
//  a stalled result register holds the execute stage, which holds the front
//
module accumulator_machine_execute_unit #(
    parameter int DATA_DEPTH = 128,
    parameter int CODE_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ame_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ame_pkg::t_out_item   o_out_data
);

    localparam int WW   = ame_pkg::WORD_W;
    localparam int RW   = ame_pkg::RECIP_W;
    localparam int QW   = ame_pkg::QUOT_W;
    localparam int AW   = $clog2(DATA_DEPTH);
    localparam int CW   = $clog2(CODE_DEPTH);
    localparam int PCW  = (CW > 8) ? CW : 8;
    localparam int PW   = RW + WW;
    localparam int DW   = QW + WW + 1;

    // ceil(2^32 / depth): floor(x * recip / 2^32) is exact for 16-bit x
    localparam logic [63:0] DATA_RECIP64 =
        ((64'd1 << 32) + 64'(DATA_DEPTH) - 64'd1) / 64'(DATA_DEPTH);
    localparam logic [63:0] CODE_RECIP64 =
        ((64'd1 << 32) + 64'(CODE_DEPTH) - 64'd1) / 64'(CODE_DEPTH);
    localparam logic [RW-1:0] DATA_RECIP = DATA_RECIP64[RW-1:0];
    localparam logic [RW-1:0] CODE_RECIP = CODE_RECIP64[RW-1:0];
    localparam logic [CW:0]   CODE_LIMIT = (CW+1)'(CODE_DEPTH);
    localparam logic [CW:0]   PC_STEP    = (CW+1)'(2);

    // ---------------- pipeline control ----------------
    logic r0_vld, r1_vld, r2_vld;
    logic move0, move1, accept;

    assign move1      = r1_vld && (!r2_vld || i_out_ready);
    assign move0      = r0_vld && (!r1_vld || move1);
    assign o_in_ready = !r0_vld || move0;
    assign accept     = i_in_valid && o_in_ready;

    // ---------------- stage 0: quotients by the depths ----------------
    ame_pkg::t_in_item r0_item;
    logic [QW-1:0]     r0_qd, r0_qc;
    logic [WW-1:0]     in_opnd;
    logic [PW-1:0]     qd_prod, qc_prod;

    assign in_opnd = i_in_data.operand;
    assign qd_prod = PW'(in_opnd) * PW'(DATA_RECIP);
    assign qc_prod = PW'(in_opnd) * PW'(CODE_RECIP);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r0_item <= i_in_data;
            r0_qd   <= qd_prod[32 +: QW];
            r0_qc   <= qc_prod[32 +: QW];
        end
    end

    // ---------------- stage 1: remainders, memory read ----------------
    logic [WW-1:0] r0_opnd;
    logic [DW-1:0] md_prod, mc_prod;
    logic [WW-1:0] rem_d, rem_c;
    logic [AW-1:0] addr0;

    assign r0_opnd = r0_item.operand;
    assign md_prod = DW'(r0_qd) * DW'(DATA_DEPTH);
    assign mc_prod = DW'(r0_qc) * DW'(CODE_DEPTH);
    assign rem_d   = r0_opnd - md_prod[WW-1:0];
    assign rem_c   = r0_opnd - mc_prod[WW-1:0];
    assign addr0   = rem_d[AW-1:0];

    ame_pkg::t_in_item r1_item;
    logic [AW-1:0]     r1_addr;
    logic [CW-1:0]     r1_target;
    logic [WW-1:0]     r1_mem_q;
    logic              r1_mem_vld;
    logic              r1_byp;
    logic [WW-1:0]     r1_byp_data;

    // data memory, one word per address, valid bits stand for the reset value
    logic [WW-1:0]     r_mem [DATA_DEPTH];
    logic              r_mem_vld [DATA_DEPTH];
    logic              wr_en;
    logic [WW-1:0]     wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r1_addr] <= wr_data;
        end
        if (move0) begin
            r1_mem_q <= r_mem[addr0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DATA_DEPTH; k++) begin
                r_mem_vld[k] <= 1'b0;
            end
        end else if (wr_en) begin
            r_mem_vld[r1_addr] <= 1'b1;
        end
    end

    // store from the execute stage in the same cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (move0) begin
            r1_item     <= r0_item;
            r1_addr     <= addr0;
            r1_target   <= rem_c[CW-1:0];
            r1_mem_vld  <= r_mem_vld[addr0];
            r1_byp      <= wr_en && (r1_addr == addr0);
            r1_byp_data <= wr_data;
        end
    end

    // ---------------- stage 2: execute ----------------
    logic [WW-1:0] r_acc;
    logic [CW-1:0] r_pc;
    logic          r_halt;

    logic [WW-1:0] n_acc;
    logic [CW-1:0] n_pc;
    logic          n_halt;
    logic          emit;
    logic [WW-1:0] mem_val;
    logic [CW:0]   pc_sum;
    logic [CW-1:0] pc_adv;
    logic [PCW-1:0] pc_wide;
    logic          is_store;

    assign mem_val = r1_byp ? r1_byp_data : (r1_mem_vld ? r1_mem_q : '0);
    assign pc_sum  = {1'b0, r_pc} + PC_STEP;
    assign pc_adv  = (pc_sum >= CODE_LIMIT) ? CW'(pc_sum - CODE_LIMIT) : pc_sum[CW-1:0];

    always_comb begin
        n_acc    = r_acc;
        n_pc     = r_pc;
        n_halt   = r_halt;
        emit     = 1'b0;
        is_store = 1'b0;
        wr_data  = r_acc;
        if (!r_halt) begin
            n_pc = pc_adv;
            unique case (r1_item.opcode)
                ame_pkg::OP_IN:  n_acc = r1_item.in_value;
                ame_pkg::OP_OUT: emit = 1'b1;
                ame_pkg::OP_LDA: n_acc = mem_val;
                ame_pkg::OP_STA: begin
                    is_store = 1'b1;
                    wr_data  = r_acc;
                end
                ame_pkg::OP_ADD: n_acc = r_acc + mem_val;
                ame_pkg::OP_SUB: n_acc = r_acc - mem_val;
                ame_pkg::OP_INC: begin
                    is_store = 1'b1;
                    wr_data  = mem_val + WW'(1);
                end
                ame_pkg::OP_DEC: begin
                    is_store = 1'b1;
                    wr_data  = mem_val - WW'(1);
                end
                ame_pkg::OP_JMP: n_pc = r1_target;
                ame_pkg::OP_JZ: begin
                    if (r_acc == '0) begin
                        n_pc = r1_target;
                    end
                end
                ame_pkg::OP_JN: begin
                    if (r_acc[WW-1]) begin
                        n_pc = r1_target;
                    end
                end
                ame_pkg::OP_LIT: n_acc = r1_item.operand;
                // halt and the undefined codes
                default:         n_halt = 1'b1;
            endcase
        end
    end

    assign wr_en   = move1 && is_store;
    assign pc_wide = PCW'(n_pc);

    // architectural state advances with each executed instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pc   <= '0;
            r_halt <= 1'b0;
        end else if (move1) begin
            r_acc  <= n_acc;
            r_pc   <= n_pc;
            r_halt <= n_halt;
        end
    end

    // ---------------- result register ----------------
    ame_pkg::t_out_item r2_item;

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r2_item.next_pc   <= pc_wide[7:0];
            r2_item.acc_value <= n_acc;
            r2_item.out_valid <= emit;
            r2_item.halted    <= n_halt;
        end
    end

    // ---------------- stage valid flags ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (accept) begin
                r0_vld <= 1'b1;
            end else if (move0) begin
                r0_vld <= 1'b0;
            end
            if (move0) begin
                r1_vld <= 1'b1;
            end else if (move1) begin
                r1_vld <= 1'b0;
            end
            if (move1) begin
                r2_vld <= 1'b1;
            end else if (i_out_ready) begin
                r2_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r2_vld;
    assign o_out_data  = r2_item;

    // ---------------- assertions ----------------
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    a_halt_holds_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> ($stable(r_acc) && $stable(r_pc)))
        else $error("state changed while halted");

    a_no_store_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !r_halt)
        else $error("memory written while halted");

    a_out_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_valid) |-> !o_out_data.halted)
        else $error("out emitted with halt set");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move1 |-> ({1'b0, n_pc} < CODE_LIMIT))
        else $error("program counter beyond code depth");

endmodule
